/* rtl/slsd_pkg.sv */
// Shared constants, codes and types of the sorted list unit.
`default_nettype none
package slsd_pkg;

    localparam int CAPACITY    = 16;
    localparam int DATA_WIDTH  = 8;
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FOUND    = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [COUNT_WIDTH-1:0]       count_t;

    // Update strobes broadcast to every cell
    typedef struct packed {
        logic insert_en;
        logic delete_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/slsd_req_if.sv */
// Request and response channel interfaces of the sorted list unit.
`default_nettype none
interface slsd_req_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    slsd_pkg::data_t       value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface slsd_rsp_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    slsd_pkg::count_t      count;

    modport source (output valid, output status, output count, input ready);
    modport sink   (input valid, input status, input count, output ready);
endinterface
`default_nettype wire

/* rtl/slsd_cell.sv */
// One cell of the sorted list: holds an element and shifts with its neighbours.
`default_nettype none
module slsd_cell (
    input  wire                       clk,
    input  wire slsd_pkg::cell_ctrl_t ctrl,
    input  wire slsd_pkg::data_t      value,
    input  wire                       occupied,
    input  wire                       left_ge,
    input  wire                       left_seen,
    input  wire slsd_pkg::data_t      left_value,
    input  wire slsd_pkg::data_t      right_value,
    output logic                      ge,
    output logic                      seen,
    output slsd_pkg::data_t           stored
);
    import slsd_pkg::*;

    data_t val_reg;
    data_t val_next;
    logic  match;

    // Cell sits at or past the insertion point when it is empty or not below the value
    assign ge     = !(occupied && (val_reg < value));
    assign match  = occupied && (val_reg == value);
    assign seen   = left_seen || match;
    assign stored = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.insert_en)
        begin
            if (left_ge)
            begin
                val_next = left_value;
            end
            else if (ge)
            begin
                val_next = value;
            end
        end
        else if (ctrl.delete_en && seen)
        begin
            // close the gap from the first match upwards
            val_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

/* rtl/sorted_list_insert_search_delete_unit.sv */
// A request's response is registered and offered in the cycle after acceptance.
// One request per cycle while responses are taken; every cell compares against
// the request at once and the whole row shifts in the same cycle, the response
// register decoupling the sides. Reset clears the element count and the response
// valid; cell contents stay undefined and are only read below the count.
`default_nettype none
module sorted_list_insert_search_delete_unit (
    input  wire       clk,
    input  wire       rst_n,
    slsd_req_if.sink  req,
    slsd_rsp_if.source rsp
);
    import slsd_pkg::*;

    count_t     count_reg;
    count_t     count_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    status_t    status_reg;
    status_t    status_next;
    count_t     rsp_count_reg;

    logic       accept;
    logic       full;
    logic       found;
    cell_ctrl_t ctrl;

    logic  [CAPACITY-1:0] cell_ge;
    logic  [CAPACITY-1:0] cell_seen;
    logic  [CAPACITY-1:0] cell_occ;
    data_t                cell_val [CAPACITY];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == COUNT_WIDTH'(CAPACITY));
    assign found     = cell_seen[CAPACITY-1];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign cell_occ[gi] = (COUNT_WIDTH'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                slsd_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .value       (req.value),
                    .occupied    (cell_occ[gi]),
                    .left_ge     (1'b0),
                    .left_seen   (1'b0),
                    .left_value  (req.value),
                    .right_value (cell_val[(gi + 1) % CAPACITY]),
                    .ge          (cell_ge[gi]),
                    .seen        (cell_seen[gi]),
                    .stored      (cell_val[gi])
                );
            end
            else if (gi == CAPACITY - 1)
            begin : g_tail
                slsd_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .value       (req.value),
                    .occupied    (cell_occ[gi]),
                    .left_ge     (cell_ge[gi-1]),
                    .left_seen   (cell_seen[gi-1]),
                    .left_value  (cell_val[gi-1]),
                    .right_value (cell_val[gi]),
                    .ge          (cell_ge[gi]),
                    .seen        (cell_seen[gi]),
                    .stored      (cell_val[gi])
                );
            end
            else
            begin : g_mid
                slsd_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .value       (req.value),
                    .occupied    (cell_occ[gi]),
                    .left_ge     (cell_ge[gi-1]),
                    .left_seen   (cell_seen[gi-1]),
                    .left_value  (cell_val[gi-1]),
                    .right_value (cell_val[gi+1]),
                    .ge          (cell_ge[gi]),
                    .seen        (cell_seen[gi]),
                    .stored      (cell_val[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = ST_ABSENT;
        case (req.req_type)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next    = ST_INSERTED;
                    ctrl.insert_en = accept;
                    count_next     = count_reg + COUNT_WIDTH'(1);
                end
            end
            OP_SEARCH:
            begin
                if (found)
                begin
                    status_next = ST_FOUND;
                end
            end
            OP_DELETE:
            begin
                if (found)
                begin
                    status_next    = ST_FOUND;
                    ctrl.delete_en = accept;
                    count_next     = count_reg - COUNT_WIDTH'(1);
                end
            end
            default:
            begin
                status_next = ST_ABSENT;
            end
        endcase
    end

    // hold the response until taken, load a fresh one on each accepted request
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            rsp_count_reg <= count_next;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.count  = rsp_count_reg;

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench of the sorted list unit: a predictor, directed and random requests.
module tb;
    import slsd_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         WATCHDOG_LIMIT  = 1000;
    localparam int         RSP_HOLD_CYCLES = 200;
    localparam int         DRAIN_CYCLES    = 4;

    typedef struct {
        status_t status;
        count_t  count;
    } list_result_t;

    logic clk;
    logic rst_n;

    slsd_req_if req_ch ();
    slsd_rsp_if rsp_ch ();

    sorted_list_insert_search_delete_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted contents of the list, ascending, valid below list_count
    data_t        list_values [CAPACITY];
    count_t       list_count;
    list_result_t pending_results [$];

    int error_count = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit req_idle_on = 1'b1;
    bit rsp_idle_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int find_value(data_t v);
        int i;
        for (i = 0; i < list_count; i++)
        begin
            if (list_values[i] == v)
                return i;
        end
        return -1;
    endfunction

    // Apply one request to the predicted list and return the response it must give
    function automatic list_result_t apply_list_request(logic [1:0] op, data_t v);
        list_result_t res;
        int pos;
        int i;
        res.status = ST_ABSENT;
        case (op)
            OP_INSERT:
            begin
                if (list_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < list_count && list_values[pos] < v)
                        pos++;
                    for (i = list_count; i > pos; i--)
                        list_values[i] = list_values[i-1];
                    list_values[pos] = v;
                    list_count++;
                    res.status = ST_INSERTED;
                end
            end
            OP_SEARCH:
            begin
                if (find_value(v) >= 0)
                    res.status = ST_FOUND;
            end
            OP_DELETE:
            begin
                pos = find_value(v);
                if (pos >= 0)
                begin
                    for (i = pos; i + 1 < list_count; i++)
                        list_values[i] = list_values[i+1];
                    list_count--;
                    res.status = ST_FOUND;
                end
            end
            default:
                res.status = ST_ABSENT;
        endcase
        res.count = list_count;
        return res;
    endfunction

    // Favour stored values so that searches and deletes hit
    function automatic data_t pick_value();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel < 2 && list_count > 0)
            return list_values[$urandom_range(0, list_count - 1)];
        else if (sel == 2)
            return data_t'(int'($urandom_range(0, 6)) - 3);
        else
            return data_t'($urandom_range(0, 255));
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return OP_INSERT;
        else if (r < 60)
            return OP_SEARCH;
        else if (r < 95)
            return OP_DELETE;
        else
            return OP_UNUSED;
    endfunction

    // Offer one request; valid stays high after acceptance so back-to-back requests need no dip
    task automatic send_request(logic [1:0] op, data_t v);
        int gap;
        gap = req_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.value    <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_results.push_back(apply_list_request(op, v));
    endtask

    task automatic test_directed();
        send_request(OP_SEARCH, 8'sd0);
        send_request(OP_DELETE, 8'sd5);
        send_request(OP_UNUSED, -8'sd1);
        send_request(OP_INSERT, 8'sd127);
        send_request(OP_INSERT, -8'sd128);
        send_request(OP_INSERT, 8'sd0);
        send_request(OP_INSERT, 8'sd0);
        send_request(OP_INSERT, -8'sd1);
        send_request(OP_INSERT, 8'sd1);
        send_request(OP_SEARCH, 8'sd127);
        send_request(OP_SEARCH, -8'sd128);
        send_request(OP_SEARCH, 8'sd2);
        send_request(OP_DELETE, 8'sd0);
        send_request(OP_SEARCH, 8'sd0);
        send_request(OP_DELETE, 8'sd0);
        send_request(OP_SEARCH, 8'sd0);
        send_request(OP_DELETE, -8'sd128);
        send_request(OP_DELETE, 8'sd127);
        send_request(OP_UNUSED, 8'sd0);
        send_request(OP_DELETE, 8'sd100);
        send_request(OP_SEARCH, -8'sd1);
    endtask

    // Fill to capacity, knock on the full list, then empty it again
    task automatic test_fill_and_drain();
        repeat (4)
        begin
            while (list_count < CAPACITY)
                send_request(OP_INSERT, pick_value());
            repeat (6)
                send_request($urandom_range(0, 1) ? OP_INSERT : OP_SEARCH, pick_value());
            while (list_count > 0)
                send_request(OP_DELETE, pick_value());
            send_request(OP_SEARCH, pick_value());
        end
    endtask

    task automatic test_random_mix();
        int blk;
        for (blk = 0; blk < 12; blk++)
        begin
            req_idle_on = blk[0];
            rsp_idle_on = blk[1];
            repeat (100)
                send_request(pick_op(), pick_value());
        end
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    // Hold the response side off while requests keep coming, so the input stalls
    task automatic test_back_pressure();
        req_idle_on = 1'b0;
        hold_left <= RSP_HOLD_CYCLES;
        repeat (150)
            send_request(pick_op(), pick_value());
        req_idle_on = 1'b1;
    endtask

    task automatic test_burst();
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        repeat (400)
            send_request(pick_op(), pick_value());
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Response side: stall at random, accept one response and compare it
    initial
    begin : response_checker
        int stall;
        list_result_t want;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rsp_idle_on ? $urandom_range(0, 11) : 0;
            if (hold_left > 0 || stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                while (hold_left > 0)
                    @(posedge clk);
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            if (pending_results.size() == 0)
            begin
                $error("unexpected response: status %0d, count %0d",
                       rsp_ch.status, rsp_ch.count);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= OP_INSERT;
        req_ch.value    <= '0;
        list_count = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_drain();
        test_random_mix();
        test_back_pressure();
        test_burst();

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
